### sv/pid_step_pkg.sv
// Shared constants for the PID controller step block.
`timescale 1ns / 1ps

package pid_step_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Upper output limit after reset, in whole units (shifted by FRAC_BITS).
  localparam int OUT_MAX_RST_UNITS = 255;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_P_ON_MEAS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_DIR  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_MEAS    = 3'd7;

endpackage

### sv/pid_controller_step.sv
// PID controller step with proportional-on-measurement option, signed fixed point.
`timescale 1ns / 1ps

// Path: a sample accepted on in_* is held in the input register, then moves into the result
//   register and is presented on out_*; a stalled pending result holds it in the input register.
// Throughput: one sample per cycle while out_stall stays low; the limit is the loop that
//   updates the integrator, last measurement and last drive through the four gain multipliers.
// Reset (rst_n low, synchronous): both stages empty, gains and out_min zero,
//   out_max 255.0, integrator, last measurement and last drive zero, manual mode.
module pid_controller_step #(
  parameter int DATA_WIDTH = pid_step_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pid_step_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [DATA_WIDTH-1:0]         in_setpoint,
  input  logic signed [DATA_WIDTH-1:0]         in_measurement,
  input  logic                                 in_auto_mode,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [DATA_WIDTH-1:0]         out_drive,
  output logic                                 out_drive_valid,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pid_step_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [DATA_WIDTH-1:0]                cfg_data
);

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW + 2;   // exact product of two DW+1 bit operands
  localparam int SW = DW + 2;       // exact sum of three DW bit terms

  localparam logic [DW-1:0] OUT_MAX_RST =
    DW'(64'(pid_step_pkg::OUT_MAX_RST_UNITS) << FRAC_BITS);

  // (a*b) >> FRAC_BITS rounding toward minus infinity, saturated to DW bits.
  function automatic logic signed [DW-1:0] mul_fix(input logic signed [DW:0] a,
                                                   input logic signed [DW:0] b);
    logic signed [PW-1:0]  prod;
    logic signed [PW-1:0]  shr;
    logic [PW-DW:0]        top;
    logic signed [DW-1:0]  res;
    prod = a * b;
    shr  = prod >>> FRAC_BITS;
    top  = shr[PW-1:DW-1];
    if ((&top) || !(|top)) begin
      res = shr[DW-1:0];
    end else if (shr[PW-1]) begin
      res = {1'b1, {(DW-1){1'b0}}};
    end else begin
      res = {1'b0, {(DW-1){1'b1}}};
    end
    return res;
  endfunction

  // Upper limit first, then lower: inverted limits give the lower one.
  function automatic logic signed [DW-1:0] clamp(input logic signed [SW-1:0] x,
                                                 input logic signed [DW-1:0] lo,
                                                 input logic signed [DW-1:0] hi);
    logic signed [SW-1:0] lo_e;
    logic signed [SW-1:0] hi_e;
    logic signed [SW-1:0] y;
    lo_e = {{2{lo[DW-1]}}, lo};
    hi_e = {{2{hi[DW-1]}}, hi};
    y = x;
    if (y > hi_e) begin
      y = hi_e;
    end
    if (y < lo_e) begin
      y = lo_e;
    end
    return y[DW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] ext2(input logic signed [DW-1:0] v);
    return {{2{v[DW-1]}}, v};
  endfunction

  // Configuration registers.
  logic signed [DW-1:0] kp_r, ki_r, kd_r, out_min_r, out_max_r;
  logic                 p_on_meas_r, rev_dir_r;

  // Controller state.
  logic signed [DW-1:0] integ_r, integ_nxt;
  logic signed [DW-1:0] prev_meas_r, prev_meas_nxt;
  logic signed [DW-1:0] prev_drive_r, prev_drive_nxt;
  logic                 auto_act_r, auto_act_nxt;

  // Input stage.
  logic                 in_vld_r;
  logic signed [DW-1:0] sp_r, meas_r;
  logic                 am_r;

  // Result stage.
  logic                 out_vld_r;
  logic signed [DW-1:0] drive_r, drive_nxt;
  logic                 drive_vld_r;

  logic in_take, advance, cfg_wr;

  // Datapath signals.
  logic signed [DW:0]   kp_e, ki_e, kd_e;
  logic signed [DW:0]   err, din;
  logic signed [DW-1:0] integ_eff;
  logic signed [DW-1:0] m_i, m_pd, m_pe, m_d;
  logic signed [SW-1:0] integ_sum, drive_sum;
  logic signed [DW-1:0] integ_clamped;

  // Handshake: the input register moves into the result register when that one is
  // empty or being drained this cycle.
  assign advance   = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign out_valid       = out_vld_r;
  assign out_drive       = drive_r;
  assign out_drive_valid = drive_vld_r;

  always_comb begin
    // Reverse acting: negate the gains exactly, one bit wider.
    kp_e = rev_dir_r ? -{kp_r[DW-1], kp_r} : {kp_r[DW-1], kp_r};
    ki_e = rev_dir_r ? -{ki_r[DW-1], ki_r} : {ki_r[DW-1], ki_r};
    kd_e = rev_dir_r ? -{kd_r[DW-1], kd_r} : {kd_r[DW-1], kd_r};

    err = {sp_r[DW-1], sp_r} - {meas_r[DW-1], meas_r};
    din = {meas_r[DW-1], meas_r} - {prev_meas_r[DW-1], prev_meas_r};

    // Bumpless transfer: on entering auto, start from the last drive.
    if (am_r && !auto_act_r) begin
      integ_eff = clamp(ext2(prev_drive_r), out_min_r, out_max_r);
    end else begin
      integ_eff = integ_r;
    end

    m_i  = mul_fix(ki_e, err);
    m_pd = mul_fix(kp_e, din);
    m_pe = mul_fix(kp_e, err);
    m_d  = mul_fix(kd_e, din);

    integ_sum = ext2(integ_eff) + ext2(m_i) - (p_on_meas_r ? ext2(m_pd) : '0);
    integ_clamped = clamp(integ_sum, out_min_r, out_max_r);

    drive_sum = (p_on_meas_r ? '0 : ext2(m_pe)) + ext2(integ_clamped) - ext2(m_d);

    // Default: hold state.
    integ_nxt      = integ_r;
    prev_meas_nxt  = prev_meas_r;
    prev_drive_nxt = prev_drive_r;
    auto_act_nxt   = auto_act_r;
    drive_nxt      = '0;

    if (advance) begin
      auto_act_nxt = am_r;
      if (am_r) begin
        drive_nxt      = clamp(drive_sum, out_min_r, out_max_r);
        integ_nxt      = integ_clamped;
        prev_drive_nxt = drive_nxt;
        prev_meas_nxt  = meas_r;
      end
    end

    // A write of the initial measurement overrides the stored one.
    if (cfg_wr && cfg_index == pid_step_pkg::CFG_INIT_MEAS) begin
      prev_meas_nxt = cfg_data;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      out_min_r   <= '0;
      out_max_r   <= OUT_MAX_RST;
      p_on_meas_r <= 1'b0;
      rev_dir_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        pid_step_pkg::CFG_PROP_GAIN:   kp_r        <= cfg_data;
        pid_step_pkg::CFG_INTEG_GAIN:  ki_r        <= cfg_data;
        pid_step_pkg::CFG_DERIV_GAIN:  kd_r        <= cfg_data;
        pid_step_pkg::CFG_OUT_MIN:     out_min_r   <= cfg_data;
        pid_step_pkg::CFG_OUT_MAX:     out_max_r   <= cfg_data;
        pid_step_pkg::CFG_P_ON_MEAS:   p_on_meas_r <= cfg_data[0];
        pid_step_pkg::CFG_REVERSE_DIR: rev_dir_r   <= cfg_data[0];
        pid_step_pkg::CFG_INIT_MEAS: begin
          // handled with the controller state
        end
      endcase
    end
  end

  // Controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r      <= '0;
      prev_meas_r  <= '0;
      prev_drive_r <= '0;
      auto_act_r   <= 1'b0;
    end else begin
      integ_r      <= integ_nxt;
      prev_meas_r  <= prev_meas_nxt;
      prev_drive_r <= prev_drive_nxt;
      auto_act_r   <= auto_act_nxt;
    end
  end

  // Input stage: load on transfer, drop when advanced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      sp_r   <= in_setpoint;
      meas_r <= in_measurement;
      am_r   <= in_auto_mode;
    end
  end

  // Result stage: hold while stalled, drop after transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive_r     <= drive_nxt;
      drive_vld_r <= am_r;
    end
  end

endmodule

### sv/pid_step_chk.sv
// Port-level checker for the PID controller step block, with its bind.
`timescale 1ns / 1ps

module pid_step_chk #(
  parameter int DATA_WIDTH = pid_step_pkg::DATA_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [DATA_WIDTH-1:0] out_drive,
  input logic                         out_drive_valid
);

  // A pending result is not withdrawn while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // The input side only backs up behind a stalled, pending result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // Every accepted sample shows up at the output, behind the input register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##1 out_valid)
    else $error("accepted sample did not reach the output");

  // A manual-mode result carries a zero drive.
  a_manual_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_drive_valid |-> out_drive == '0)
    else $error("manual result with nonzero drive");

  // Reset empties the result stage.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind pid_controller_step pid_step_chk #(.DATA_WIDTH(DATA_WIDTH)) u_pid_step_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_drive       (out_drive),
  .out_drive_valid (out_drive_valid)
);
